// File: sv/priority_ordered_handle_list_defines.svh
// ----------------------------------------------------------------------------
// priority_ordered_handle_list assertion macros
// Shared property shorthands for the handle list block, clocked on clk and
// disabled while arst_n is low.
// ----------------------------------------------------------------------------
`ifndef PRIORITY_ORDERED_HANDLE_LIST_DEFINES_SVH
`define PRIORITY_ORDERED_HANDLE_LIST_DEFINES_SVH

// same-cycle implication
`define POHL_ASSERT_IMP(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("handle list assertion failed");

// next-cycle implication
`define POHL_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("handle list assertion failed");

`endif

// File: sv/pohl_pkg.sv
// ----------------------------------------------------------------------------
// pohl_pkg
// Types, constants and helpers shared by the handle list cells and the
// sequencer that drives them.
// ----------------------------------------------------------------------------
`default_nettype none

package pohl_pkg;

	// table geometry
	localparam int MAX_SLOTS   = 16;
	localparam int MAX_RESULTS = 16;
	localparam int IDX_W       = $clog2(MAX_SLOTS);
	localparam int CNT_W       = $clog2(MAX_SLOTS + 1);
	localparam int RES_W       = $clog2(MAX_RESULTS);

	// field widths
	localparam int HANDLE_W = 32;
	localparam int PRIO_W   = 16;
	localparam int SIZE_W   = 5;

	localparam logic [SIZE_W-1:0] TABLE_SIZE_RESET = SIZE_W'(16);

	// operation codes
	typedef enum logic [1:0] {
		OP_DISPATCH = 2'd0,
		OP_INSERT   = 2'd1,
		OP_REMOVE   = 2'd2,
		OP_LOOKUP   = 2'd3
	} op_t;

	// what each cell compares against
	typedef enum logic [2:0] {
		CMP_EMPTY,
		CMP_BEFORE,
		CMP_PRIO,
		CMP_REMOVE,
		CMP_LOOKUP
	} cmp_t;

	// what each cell does with the result
	typedef enum logic [2:0] {
		ACT_NONE,
		ACT_LOAD,
		ACT_INSERT,
		ACT_PULL,
		ACT_CLEAR
	} act_t;

	typedef struct packed {
		logic [HANDLE_W-1:0] handle;
		logic [PRIO_W-1:0]   prio;
	} slot_t;

	// broadcast from the sequencer to every cell
	typedef struct packed {
		act_t                act;
		cmp_t                cmp;
		logic [HANDLE_W-1:0] key;
		logic [HANDLE_W-1:0] before_key;
		logic [PRIO_W-1:0]   key_prio;
		logic [PRIO_W-1:0]   new_prio;
		logic [PRIO_W-1:0]   fill_prio;
	} cell_ctl_t;

	// clamp the configured size into the legal slot range
	function automatic logic [CNT_W-1:0] used_slots(input logic [SIZE_W-1:0] ts);
		logic [CNT_W-1:0] n;
		if (ts < SIZE_W'(2)) begin
			n = CNT_W'(2);
		end else if (32'(ts) > MAX_SLOTS) begin
			n = CNT_W'(MAX_SLOTS);
		end else begin
			n = CNT_W'(ts);
		end
		return n;
	endfunction

endpackage

`default_nettype wire

// File: sv/pohl_cell.sv
// ----------------------------------------------------------------------------
// pohl_cell
// One slot of the handle list. Compares its entry against the broadcast key,
// passes the first-match flag up the chain and loads from itself, the new
// entry, or a neighbor.
// ----------------------------------------------------------------------------
`default_nettype none

module pohl_cell (
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire pohl_pkg::cell_ctl_t    ctl,
	input  wire logic                   active,
	input  wire logic                   upper_active,
	input  wire logic                   seen_in,
	input  wire pohl_pkg::slot_t        lower,
	input  wire pohl_pkg::slot_t        upper,
	output logic                        seen_out,
	output pohl_pkg::slot_t             slot
);

	pohl_pkg::slot_t slot_q;
	pohl_pkg::slot_t slot_n;
	logic            cond;
	logic            hit;
	logic            first;
	logic            after;

	// compare against the broadcast key
	always_comb begin
		case (ctl.cmp)
			pohl_pkg::CMP_EMPTY:  cond = (slot_q.handle == '0);
			pohl_pkg::CMP_BEFORE: cond = (slot_q.handle == ctl.before_key);
			pohl_pkg::CMP_PRIO:   cond = ($signed(ctl.key_prio) < $signed(slot_q.prio))
				|| (slot_q.handle == '0);
			pohl_pkg::CMP_REMOVE: cond = (slot_q.handle == ctl.key);
			pohl_pkg::CMP_LOOKUP: cond = (slot_q.handle == ctl.key)
				&& (slot_q.prio == {8'h00, ctl.key_prio[7:0]});
			default:              cond = 1'b0;
		endcase
	end

	// first-match chain
	assign hit      = active && cond;
	assign first    = hit && !seen_in;
	assign after    = seen_in && active;
	assign seen_out = seen_in || hit;

	// next slot contents
	always_comb begin
		slot_n = slot_q;
		case (ctl.act)
			pohl_pkg::ACT_LOAD: begin
				if (first) begin
					slot_n.handle = ctl.key;
					slot_n.prio   = ctl.new_prio;
				end
			end
			pohl_pkg::ACT_INSERT: begin
				if (first) begin
					slot_n.handle = ctl.key;
					slot_n.prio   = ctl.new_prio;
				end else if (after) begin
					slot_n = lower;
				end
			end
			pohl_pkg::ACT_PULL: begin
				if (first || after) begin
					if (upper_active) begin
						slot_n = upper;
					end else begin
						slot_n.handle = '0;
						slot_n.prio   = ctl.fill_prio;
					end
				end
			end
			pohl_pkg::ACT_CLEAR: slot_n = '0;
			default:             slot_n = slot_q;
		endcase
	end

	// slot register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			slot_q <= '0;
		end else begin
			slot_q <= slot_n;
		end
	end

	assign slot = slot_q;

endmodule

`default_nettype wire

// File: sv/priority_ordered_handle_list.sv
// ----------------------------------------------------------------------------
// priority_ordered_handle_list
// Sorted table of handle/priority pairs with insert, remove, lookup and
// dispatch, built as a chain of slot cells under one sequencer.
// ----------------------------------------------------------------------------
// One item is worked at a time; in_stall is high from acceptance until the
// last result beat is loaded. Insert and lookup accept the item, then make
// one pass through the cell chain. Remove makes one pass of the chain per
// entry deleted, each pass pulling out the first matching entry, and then
// a last pass that finds none. Dispatch walks the slots with a pointer, one
// slot per cycle while the output is not stalled; every occupied slot is one
// result beat. A stalled output holds the sequencer whenever it has a result
// beat to load. Writing table_size clears every slot in the same cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module priority_ordered_handle_list (
	input  wire logic                                 clk,
	input  wire logic                                 arst_n,
	// configuration
	input  wire logic                                 cfg_wr_en,
	input  wire logic [pohl_pkg::SIZE_W-1:0]          cfg_wr_data,
	// input channel
	input  wire logic                                 in_valid,
	output logic                                      in_stall,
	input  wire logic [1:0]                           operation,
	input  wire logic [pohl_pkg::HANDLE_W-1:0]        handle,
	input  wire logic [pohl_pkg::HANDLE_W-1:0]        before_handle,
	input  wire logic signed [pohl_pkg::PRIO_W-1:0]   priority_req,
	// output channel
	output logic                                      out_valid,
	input  wire logic                                 out_stall,
	output logic                                      status,
	output logic                                      found,
	output logic [pohl_pkg::HANDLE_W-1:0]             out_handle,
	output logic [pohl_pkg::HANDLE_W-1:0]             out_argument,
	output logic                                      last
);

`include "priority_ordered_handle_list_defines.svh"

	localparam int NS = pohl_pkg::MAX_SLOTS;

	typedef enum logic [1:0] {
		S_IDLE,
		S_EXEC,
		S_DISP
	} state_t;

	state_t                                state_q;
	pohl_pkg::op_t                         op_q;
	logic [pohl_pkg::HANDLE_W-1:0]         handle_q;
	logic [pohl_pkg::HANDLE_W-1:0]         before_q;
	logic [pohl_pkg::PRIO_W-1:0]           prio_q;
	logic [pohl_pkg::PRIO_W-1:0]           fill_q;
	logic [pohl_pkg::SIZE_W-1:0]           table_size_q;
	logic [pohl_pkg::CNT_W-1:0]            limit_q;
	logic [pohl_pkg::IDX_W-1:0]            ptr_q;
	logic [pohl_pkg::RES_W-1:0]            cnt_q;
	logic                                  out_valid_q;
	logic                                  status_q;
	logic                                  found_q;
	logic [pohl_pkg::HANDLE_W-1:0]         out_handle_q;
	logic [pohl_pkg::HANDLE_W-1:0]         out_argument_q;
	logic                                  last_q;

	pohl_pkg::cell_ctl_t                   ctl;
	pohl_pkg::slot_t                       slots   [NS];
	pohl_pkg::slot_t                       lower_s [NS];
	pohl_pkg::slot_t                       upper_s [NS];
	logic [NS:0]                           seen;
	logic [NS-1:0]                         active;
	logic [NS-1:0]                         upper_act;
	logic [NS-1:0]                         occ;
	logic [pohl_pkg::CNT_W-1:0]            used_n;
	logic [pohl_pkg::IDX_W-1:0]            top_idx;
	logic                                  full;
	logic                                  out_free;
	logic                                  chain_hit;
	logic                                  more;
	logic                                  cur_occ;
	logic                                  disp_last;
	logic                                  beat_load;

	// table geometry and occupancy
	assign used_n  = pohl_pkg::used_slots(table_size_q);
	assign top_idx = pohl_pkg::IDX_W'(used_n - pohl_pkg::CNT_W'(1));
	assign full    = (slots[top_idx].handle != '0);

	always_comb begin
		for (int i = 0; i < NS; i++) begin
			active[i] = (pohl_pkg::CNT_W'(i) < limit_q);
			occ[i]    = active[i] && (slots[i].handle != '0);
		end
		for (int i = 0; i < NS; i++) begin
			upper_act[i] = (i < NS - 1) ? active[(i + 1) % NS] : 1'b0;
			upper_s[i]   = (i < NS - 1) ? slots[(i + 1) % NS] : '0;
			lower_s[i]   = (i > 0) ? slots[(i + NS - 1) % NS] : '0;
		end
	end

	// dispatch scan: is anything occupied above the pointer
	always_comb begin
		more = 1'b0;
		for (int i = 0; i < NS; i++) begin
			if (occ[i] && (pohl_pkg::IDX_W'(i) > ptr_q)) begin
				more = 1'b1;
			end
		end
	end

	assign cur_occ   = occ[ptr_q];
	assign disp_last = !more || (cnt_q == pohl_pkg::RES_W'(pohl_pkg::MAX_RESULTS - 1));
	assign out_free  = !out_valid_q || !out_stall;
	assign chain_hit = seen[NS];

	// a result beat is loaded this cycle
	assign beat_load = out_free
		&& (((state_q == S_EXEC) && (op_q != pohl_pkg::OP_DISPATCH)
			&& !((op_q == pohl_pkg::OP_REMOVE) && chain_hit))
		|| ((state_q == S_DISP) && (cur_occ || !more)));

	// cell chain broadcast
	always_comb begin
		ctl.act        = pohl_pkg::ACT_NONE;
		ctl.cmp        = pohl_pkg::CMP_LOOKUP;
		ctl.key        = handle_q;
		ctl.before_key = before_q;
		ctl.key_prio   = prio_q;
		ctl.new_prio   = '0;
		ctl.fill_prio  = fill_q;
		if (cfg_wr_en) begin
			ctl.act = pohl_pkg::ACT_CLEAR;
		end else if (state_q == S_EXEC) begin
			case (op_q)
				pohl_pkg::OP_INSERT: begin
					if (before_q == '0 && prio_q == '0) begin
						ctl.cmp = pohl_pkg::CMP_EMPTY;
						ctl.act = pohl_pkg::ACT_LOAD;
					end else if (before_q != '0) begin
						ctl.cmp = pohl_pkg::CMP_BEFORE;
						ctl.act = pohl_pkg::ACT_INSERT;
					end else begin
						ctl.cmp      = pohl_pkg::CMP_PRIO;
						ctl.act      = pohl_pkg::ACT_INSERT;
						ctl.new_prio = prio_q;
					end
					if (!out_free || full) begin
						ctl.act = pohl_pkg::ACT_NONE;
					end
				end
				pohl_pkg::OP_REMOVE: begin
					ctl.cmp = pohl_pkg::CMP_REMOVE;
					ctl.act = pohl_pkg::ACT_PULL;
				end
				pohl_pkg::OP_LOOKUP: ctl.cmp = pohl_pkg::CMP_LOOKUP;
				default:             ctl.act = pohl_pkg::ACT_NONE;
			endcase
		end
	end

	// row of slot cells
	assign seen[0] = 1'b0;

	for (genvar g = 0; g < NS; g++) begin : g_cell
		pohl_cell u_cell (
			.clk          (clk),
			.arst_n       (arst_n),
			.ctl          (ctl),
			.active       (active[g]),
			.upper_active (upper_act[g]),
			.seen_in      (seen[g]),
			.lower        (lower_s[g]),
			.upper        (upper_s[g]),
			.seen_out     (seen[g+1]),
			.slot         (slots[g])
		);
	end

	// sequencer and result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= S_IDLE;
			op_q           <= pohl_pkg::OP_DISPATCH;
			handle_q       <= '0;
			before_q       <= '0;
			prio_q         <= '0;
			fill_q         <= '0;
			table_size_q   <= pohl_pkg::TABLE_SIZE_RESET;
			limit_q        <= '0;
			ptr_q          <= '0;
			cnt_q          <= '0;
			out_valid_q    <= 1'b0;
			status_q       <= 1'b0;
			found_q        <= 1'b0;
			out_handle_q   <= '0;
			out_argument_q <= '0;
			last_q         <= 1'b0;
		end else begin
			if (out_valid_q && !out_stall && !beat_load) begin
				out_valid_q <= 1'b0;
			end
			if (cfg_wr_en) begin
				table_size_q <= cfg_wr_data;
			end
			case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						op_q     <= pohl_pkg::op_t'(operation);
						handle_q <= handle;
						before_q <= before_handle;
						prio_q   <= priority_req;
						limit_q  <= used_n;
						fill_q   <= slots[top_idx].prio;
						ptr_q    <= '0;
						cnt_q    <= '0;
						state_q  <= (pohl_pkg::op_t'(operation) == pohl_pkg::OP_DISPATCH)
							? S_DISP : S_EXEC;
					end
				end
				S_EXEC: begin
					case (op_q)
						pohl_pkg::OP_REMOVE: begin
							// one entry pulled per pass until none is left
							if (chain_hit) begin
								limit_q <= limit_q - pohl_pkg::CNT_W'(1);
							end else if (out_free) begin
								out_valid_q    <= 1'b1;
								status_q       <= 1'b0;
								found_q        <= 1'b0;
								out_handle_q   <= '0;
								out_argument_q <= '0;
								last_q         <= 1'b1;
								state_q        <= S_IDLE;
							end
						end
						pohl_pkg::OP_INSERT: begin
							if (out_free) begin
								out_valid_q    <= 1'b1;
								status_q       <= full;
								found_q        <= 1'b0;
								out_handle_q   <= '0;
								out_argument_q <= '0;
								last_q         <= 1'b1;
								state_q        <= S_IDLE;
							end
						end
						pohl_pkg::OP_LOOKUP: begin
							if (out_free) begin
								out_valid_q    <= 1'b1;
								status_q       <= 1'b0;
								found_q        <= chain_hit;
								out_handle_q   <= '0;
								out_argument_q <= '0;
								last_q         <= 1'b1;
								state_q        <= S_IDLE;
							end
						end
						default: state_q <= S_IDLE;
					endcase
				end
				S_DISP: begin
					if (cur_occ) begin
						if (out_free) begin
							out_valid_q    <= 1'b1;
							status_q       <= 1'b0;
							found_q        <= 1'b0;
							out_handle_q   <= slots[ptr_q].handle;
							out_argument_q <= handle_q;
							last_q         <= disp_last;
							if (disp_last) begin
								state_q <= S_IDLE;
							end else begin
								ptr_q <= ptr_q + pohl_pkg::IDX_W'(1);
								cnt_q <= cnt_q + pohl_pkg::RES_W'(1);
							end
						end
					end else if (!more) begin
						// empty table gives a single null beat
						if (out_free) begin
							out_valid_q    <= 1'b1;
							status_q       <= 1'b0;
							found_q        <= 1'b0;
							out_handle_q   <= '0;
							out_argument_q <= '0;
							last_q         <= 1'b1;
							state_q        <= S_IDLE;
						end
					end else begin
						ptr_q <= ptr_q + pohl_pkg::IDX_W'(1);
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// ports
	assign in_stall     = (state_q != S_IDLE);
	assign out_valid    = out_valid_q;
	assign status       = status_q;
	assign found        = found_q;
	assign out_handle   = out_handle_q;
	assign out_argument = out_argument_q;
	assign last         = last_q;

	// checks
	`POHL_ASSERT_IMP(a_limit_bound, state_q != S_IDLE, limit_q <= used_n)
	`POHL_ASSERT_NEXT(a_remove_shrinks, state_q == S_EXEC && op_q == pohl_pkg::OP_REMOVE && chain_hit && !cfg_wr_en, limit_q == $past(limit_q) - pohl_pkg::CNT_W'(1))
	`POHL_ASSERT_IMP(a_mid_beat_handle, out_valid && !last, out_handle != '0)
	`POHL_ASSERT_IMP(a_full_only_insert, out_valid && status, !found && out_handle == '0)

endmodule

`default_nettype wire
